FILE: sv/dcr_pkg.sv
// Shared constants and types for the duplicate check and rank block.
// Used by the controller, the datapath, the top level and the port checker.
package dcr_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int VALUE_W     = 32;
	localparam int RANK_W      = 6;
	localparam int STATUS_W    = 2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_RANK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SORTED   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                load;
		logic                finish;
		logic                rd_en;
		logic [IDX_W-1:0]    rd_addr;
		logic                cmp_en;
		logic [IDX_W-1:0]    cmp_idx;
		logic                shift;
		logic                emit;
		logic [STATUS_W-1:0] emit_status;
		logic                emit_final;
	} dcr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             overflow;
		logic             dup;
		logic             ascending;
	} dcr_stat_t;

endpackage

FILE: sv/dcr_ctrl.sv
// Controller of the duplicate check and rank block: load, check, pass, decide, output.
// Depends on dcr_pkg for the command and status types.
module dcr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              last,
	input  logic              skip_dup,
	input  dcr_pkg::dcr_stat_t stat,
	output logic              busy,
	output dcr_pkg::dcr_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHK    = 3'd1;
	localparam logic [2:0] S_PASS   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_OUT    = 3'd4;

	logic [2:0]                state_q, state_d;
	logic [dcr_pkg::CNT_W-1:0] k_q, k_d;
	logic [dcr_pkg::CNT_W-1:0] k_inc, k_dec;
	logic                      accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);
	assign k_inc  = k_q + dcr_pkg::CNT_W'(1);
	assign k_dec  = k_q - dcr_pkg::CNT_W'(1);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		k_d      = k_q;
		cmd.load = accept;
		unique case (state_q)
			S_IDLE: begin
				if (accept && last) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.overflow) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = dcr_pkg::ST_OVERFLOW;
					cmd.emit_final  = 1'b1;
					cmd.finish      = 1'b1;
					state_d         = S_IDLE;
				end else begin
					k_d     = '0;
					state_d = S_PASS;
				end
			end
			S_PASS: begin
				// Read entry k while entry k-1 is compared against the cell row.
				cmd.rd_en   = (k_q < stat.count);
				cmd.rd_addr = k_q[dcr_pkg::IDX_W-1:0];
				cmd.cmp_en  = (k_q != '0);
				cmd.cmp_idx = k_dec[dcr_pkg::IDX_W-1:0];
				if (k_q == stat.count) begin
					state_d = S_DECIDE;
				end else begin
					k_d = k_inc;
				end
			end
			S_DECIDE: begin
				if (stat.dup && !skip_dup) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = dcr_pkg::ST_DUP;
					cmd.emit_final  = 1'b1;
					cmd.finish      = 1'b1;
					state_d         = S_IDLE;
				end else if (stat.ascending) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = dcr_pkg::ST_SORTED;
					cmd.emit_final  = 1'b1;
					cmd.finish      = 1'b1;
					state_d         = S_IDLE;
				end else begin
					k_d     = '0;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				cmd.emit        = 1'b1;
				cmd.emit_status = dcr_pkg::ST_RANK;
				cmd.emit_final  = (k_inc == stat.count);
				cmd.shift       = 1'b1;
				if (k_inc == stat.count) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					k_d = k_inc;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

endmodule

FILE: sv/dcr_dpath.sv
// Datapath of the duplicate check and rank block: entry memory, compare cells, result registers.
// Depends on dcr_pkg for constants and the command and status types.
module dcr_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dcr_pkg::dcr_cmd_t                      cmd,
	input  logic signed [dcr_pkg::VALUE_W-1:0]    value,
	output dcr_pkg::dcr_stat_t                     stat,
	output logic                                  res_strobe,
	output logic [dcr_pkg::RANK_W-1:0]            rank,
	output logic [dcr_pkg::STATUS_W-1:0]          status,
	output logic                                  final_res
);

	localparam int N = dcr_pkg::MAX_ENTRIES;

	logic signed [dcr_pkg::VALUE_W-1:0] mem [N];
	logic signed [dcr_pkg::VALUE_W-1:0] rd_q;
	logic signed [dcr_pkg::VALUE_W-1:0] cell_v [N];
	logic [dcr_pkg::IDX_W-1:0]          cell_r [N];
	logic [N-1:0]                       cell_ok;
	logic [N-1:0]                       eq_hit;
	logic [N-1:0]                       asc_ok;
	logic [dcr_pkg::CNT_W-1:0]          count_q;
	logic                               ovf_q;
	logic                               dup_q;
	logic                               room;
	logic                               strobe_q;
	logic [dcr_pkg::RANK_W-1:0]         rank_q;
	logic [dcr_pkg::STATUS_W-1:0]       status_q;
	logic                               final_q;

	assign room = (count_q < dcr_pkg::CNT_W'(N));

	// Entry memory: written in load order, read once per entry during the pass.
	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			mem[count_q[dcr_pkg::IDX_W-1:0]] <= value;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[cmd.rd_addr];
		end
	end

	// Cell row: each cell keeps one entry and counts broadcast entries below it.
	// During output the rank counters shift toward cell 0.
	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			logic [dcr_pkg::IDX_W-1:0] next_r;

			assign cell_ok[gi] = (dcr_pkg::CNT_W'(gi) < count_q);
			assign eq_hit[gi]  = cell_ok[gi] && (cell_v[gi] == rd_q)
				&& (dcr_pkg::IDX_W'(gi) != cmd.cmp_idx);

			if (gi == 0) begin : g_first
				assign asc_ok[gi] = 1'b1;
			end else begin : g_rest
				assign asc_ok[gi] = !cell_ok[gi] || (cell_v[gi-1] < cell_v[gi]);
			end

			if (gi < N - 1) begin : g_mid
				assign next_r = cell_r[gi+1];
			end else begin : g_end
				assign next_r = '0;
			end

			always_ff @(posedge clk) begin
				if (cmd.load && (count_q == dcr_pkg::CNT_W'(gi))) begin
					cell_v[gi] <= value;
					cell_r[gi] <= '0;
				end else if (cmd.cmp_en && cell_ok[gi] && (cell_v[gi] > rd_q)) begin
					cell_r[gi] <= cell_r[gi] + dcr_pkg::IDX_W'(1);
				end else if (cmd.shift) begin
					cell_r[gi] <= next_r;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			dup_q   <= 1'b0;
		end else if (cmd.finish) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			dup_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (room) begin
					count_q <= count_q + dcr_pkg::CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.cmp_en && (|eq_hit)) begin
				dup_q <= 1'b1;
			end
		end
	end

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rank_q   <= (cmd.emit_status == dcr_pkg::ST_RANK)
				? dcr_pkg::RANK_W'(cell_r[0]) : '0;
			status_q <= cmd.emit_status;
			final_q  <= cmd.emit_final;
		end
	end

	assign stat.count     = count_q;
	assign stat.overflow  = ovf_q;
	assign stat.dup       = dup_q;
	assign stat.ascending = &asc_ok;

	assign res_strobe = strobe_q;
	assign rank       = rank_q;
	assign status     = status_q;
	assign final_res  = final_q;

endmodule

FILE: sv/duplicate_check_and_rank.sv
// Top level of the duplicate check and rank block: configuration register and submodules.
// Depends on dcr_pkg, dcr_ctrl and dcr_dpath.
//
// A list of signed 32-bit entries is loaded one request per cycle while busy is low; the
// request with last set closes the list, and busy then stays high until the answer has been
// issued. An overflowed list is answered from the check state. Otherwise the stored
// entries are streamed from the entry memory's single read port past a row of compare
// cells, one entry a cycle, followed by a decision state; a duplicate or sorted answer is a
// single result, while a rank answer issues a result per entry, one per cycle, in load
// order. Each result is shown for exactly one cycle with res_strobe high and cannot be held
// off by the receiver; the final result appears in the same cycle as busy falls, and a new
// list may already start loading in that cycle.
module duplicate_check_and_rank (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration port.
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [2:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	// Request side.
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [dcr_pkg::VALUE_W-1:0]    value,
	input  logic                                  last,
	// Result side.
	output logic                                  res_strobe,
	output logic [dcr_pkg::RANK_W-1:0]            rank,
	output logic [dcr_pkg::STATUS_W-1:0]          status,
	output logic                                  final_res
);

	// The register index is the address bit above the byte offset.
	localparam logic REG_SKIP_DUP = 1'b0;

	logic              skip_q;
	dcr_pkg::dcr_cmd_t  cmd;
	dcr_pkg::dcr_stat_t stat;

	// The port never waits. Only bit 0 of the written data is kept, and writes to an
	// index past the register list are dropped.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_SKIP_DUP)) begin
			skip_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_SKIP_DUP) ? {31'd0, skip_q} : 32'd0;

	// The controller sequences the phases; the datapath holds the entries and
	// does all comparing and counting.
	dcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last     (last),
		.skip_dup (skip_q),
		.stat     (stat),
		.busy     (busy),
		.cmd      (cmd)
	);

	dcr_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (value),
		.stat       (stat),
		.res_strobe (res_strobe),
		.rank       (rank),
		.status     (status),
		.final_res  (final_res)
	);

endmodule

FILE: sv/dcr_checker.sv
// Port-level checks for the duplicate check and rank block, bound to its top level.
// Depends on dcr_pkg for the status codes.
module dcr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            last,
	input logic                            res_strobe,
	input logic [dcr_pkg::RANK_W-1:0]      rank,
	input logic [dcr_pkg::STATUS_W-1:0]    status,
	input logic                            final_res
);

	// A request that does not close its list never causes a result.
	a_nonlast_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last) |=> !res_strobe)
		else $error("result after a request without last");

	// Closing a list makes the block busy in the next cycle.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last) |=> busy)
		else $error("block not busy after the closing request");

	// Any status other than rank is a lone final result with rank zero.
	a_single_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && (status != dcr_pkg::ST_RANK)) |-> (final_res && (rank == '0)))
		else $error("non-rank status not final or with nonzero rank");

	// Ranks come in an unbroken run up to the final one.
	a_rank_run: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && !final_res) |=> (res_strobe && (status == dcr_pkg::ST_RANK)))
		else $error("rank run broken before its final result");

	// The final result of a list is followed by a quiet cycle.
	a_gap_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && final_res) |=> !res_strobe)
		else $error("result directly after a final result");

endmodule

bind duplicate_check_and_rank dcr_checker u_dcr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.last       (last),
	.res_strobe (res_strobe),
	.rank       (rank),
	.status     (status),
	.final_res  (final_res)
);
